// ===== rtl/eul_pkg.sv =====
// shared types and constants for the encoder position unwrap block
package eul_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned LEAP_W  = 31;
    localparam int unsigned CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_TURN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAP_VALUE     = 1'd1;

    typedef logic [DATA_W-1:0] word_t;

    // configuration seen by the datapath
    typedef struct packed {
        word_t             ticks_per_turn;
        logic [LEAP_W-1:0] leap_value;
    } cfg_t;

    // running unwrap state
    typedef struct packed {
        word_t last_raw;
        word_t leap_accum;
        word_t position;
    } track_t;

endpackage

// ===== rtl/eul_if.sv =====
// channel interfaces: sample input, position output, configuration writes
interface eul_in_if;
    logic                 valid;
    logic                 ready;
    logic [32-1:0]        raw_count;

    modport source (output valid, output raw_count, input ready);
    modport sink   (input valid, input raw_count, output ready);
endinterface

interface eul_out_if;
    logic                 valid;
    logic                 ready;
    logic [32-1:0]        position;

    modport source (output valid, output position, input ready);
    modport sink   (input valid, input position, output ready);
endinterface

interface eul_cfg_if;
    logic                 valid;
    logic                 ready;
    logic [1-1:0]         index;
    logic [32-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/eul_cfg_regs.sv =====
// configuration register file for ticks per turn and leap value
module eul_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    eul_cfg_if.sink       cfg,
    output eul_pkg::cfg_t cfg_out
);
    import eul_pkg::*;

    word_t             ticks_reg;
    logic [LEAP_W-1:0] leap_reg;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= '0;
            leap_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TICKS_PER_TURN: ticks_reg <= cfg.data;
                REG_LEAP_VALUE:     leap_reg  <= cfg.data[LEAP_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg_out.ticks_per_turn = ticks_reg;
    assign cfg_out.leap_value     = leap_reg;

endmodule

// ===== rtl/eul_step.sv =====
// one unwrap step: wrap correction, leap accumulator and position update
module eul_step (
    input  eul_pkg::word_t  cur,
    input  eul_pkg::cfg_t   cfg,
    input  eul_pkg::track_t state,
    output eul_pkg::track_t state_next
);
    import eul_pkg::*;

    word_t   leap_ext;
    word_t   neg_leap;
    word_t   diff_raw;
    word_t   mag;
    logic    wrap;
    word_t   diff;
    word_t   acc_sum;
    logic    below;
    word_t   acc_lo;
    word_t   pos_lo;
    logic    above;
    word_t   acc_fix;
    word_t   pos_fix;

    assign leap_ext = {1'b0, cfg.leap_value};
    assign neg_leap = word_t'(0) - leap_ext;

    // signed step and wrap-around correction
    assign diff_raw = state.last_raw - cur;
    assign mag      = diff_raw[DATA_W-1] ? (word_t'(0) - diff_raw) : diff_raw;
    assign wrap     = {mag, 1'b0} > {1'b0, cfg.ticks_per_turn};

    always_comb
    begin
        if (!wrap)
            diff = diff_raw;
        else if (state.last_raw < cur)
            diff = diff_raw + cfg.ticks_per_turn;
        else
            diff = diff_raw - cfg.ticks_per_turn;
    end

    // leap band, lower bound checked first
    assign acc_sum = state.leap_accum + diff;
    assign below   = $signed(acc_sum) < $signed(neg_leap);
    assign acc_lo  = below ? (acc_sum + leap_ext) : acc_sum;
    assign pos_lo  = below ? (state.position - word_t'(1)) : state.position;
    assign above   = $signed(leap_ext) < $signed(acc_lo);
    assign acc_fix = above ? (acc_lo - leap_ext) : acc_lo;
    assign pos_fix = above ? (pos_lo + word_t'(1)) : pos_lo;

    // bypass keeps last sample and accumulator
    always_comb
    begin
        if (cfg.leap_value == '0)
        begin
            state_next.last_raw   = state.last_raw;
            state_next.leap_accum = state.leap_accum;
            state_next.position   = cur;
        end
        else
        begin
            state_next.last_raw   = cur;
            state_next.leap_accum = acc_fix;
            state_next.position   = pos_fix + diff;
        end
    end

endmodule

// ===== rtl/encoder_unwrap_leap_tick.sv =====
// encoder position unwrap with leap-tick correction, top level
// a sample passes the input register and then the state/result register on its way out
// throughput: one sample per cycle; the input register feeds the step logic
// and the state/result registers, stalling only when the result is not taken
// reset: configuration, unwrap state and valid flags clear to zero,
// so the block starts in bypass mode at position zero
module encoder_unwrap_leap_tick #(
    parameter int unsigned RAW_WIDTH = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    eul_in_if.sink     samples,
    eul_out_if.source  positions,
    eul_cfg_if.sink    cfg
);
    import eul_pkg::*;

    localparam word_t RAW_MASK = DATA_W'((64'd1 << RAW_WIDTH) - 64'd1);

    cfg_t   cfg_cur;
    track_t state_reg;
    track_t state_next;
    logic   s1_valid_reg;
    word_t  s1_raw_reg;
    logic   out_valid_reg;
    logic   advance;
    logic   step;

    eul_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    eul_step u_step (
        .cur        (s1_raw_reg),
        .cfg        (cfg_cur),
        .state      (state_reg),
        .state_next (state_next)
    );

    // pipeline moves whenever the result register is free or being taken
    assign advance       = !out_valid_reg || positions.ready;
    assign step          = s1_valid_reg && advance;
    assign samples.ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (samples.ready)
            s1_valid_reg <= samples.valid;
    end

    always_ff @(posedge clk)
    begin
        if (samples.valid && samples.ready)
            s1_raw_reg <= samples.raw_count & RAW_MASK;
    end

    // unwrap state, which also holds the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (step)
                state_reg <= state_next;
        end
    end

    assign positions.valid    = out_valid_reg;
    assign positions.position = state_reg.position;

`ifndef SYNTH
    // bypass hands the masked sample straight to the result
    a_bypass_pos: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg_cur.leap_value == '0
        |=> positions.position == $past(s1_raw_reg & RAW_MASK))
        else $error("bypass position does not match sample");

    // bypass leaves the last sample and accumulator alone
    a_bypass_hold: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg_cur.leap_value == '0
        |=> $stable(state_reg.last_raw) && $stable(state_reg.leap_accum))
        else $error("bypass changed unwrap state");

    // state only moves when an item leaves the input register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg))
        else $error("unwrap state changed without an item");

    // a full, stalled input register must not take another sample
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |-> !samples.ready)
        else $error("sample accepted while input register stalled");

    // normal mode records the sample it just used
    a_last_raw: assert property (@(posedge clk) disable iff (!rst_n)
        step && cfg_cur.leap_value != '0
        |=> state_reg.last_raw == $past(s1_raw_reg))
        else $error("last sample not recorded");
`endif

endmodule

// ===== tb/sv/eul_position_checker.sv =====
// position checker: tracks unwrap state from observed transactions and compares results
module eul_position_checker #(
    parameter int unsigned RAW_WIDTH = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    eul_in_if      samples,
    eul_out_if     positions,
    eul_cfg_if     cfg,
    output int     fail_count,
    output int     pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import eul_pkg::*;

    localparam word_t RAW_MASK = (RAW_WIDTH >= 32) ? '1 : word_t'((64'd1 << RAW_WIDTH) - 1);

    // mirrored configuration
    word_t             ticks_cfg;
    logic [LEAP_W-1:0] leap_cfg;

    // mirrored unwrap state
    word_t last_sample;
    word_t leap_sum;
    word_t pos_track;

    word_t expected_positions[$];

    // advance the mirrored state by one sample and return the new position
    function automatic word_t unwrap_position(input word_t sample);
        word_t cur;
        word_t prev;
        word_t step;
        word_t mag;
        word_t lim;
        word_t acc;
        word_t pos;
        cur = sample & RAW_MASK;
        // bypass: position follows the sample, history untouched
        if (leap_cfg == '0)
        begin
            pos_track = cur;
            return cur;
        end
        prev = last_sample;
        last_sample = cur;
        step = prev - cur;
        // wrap test on the unsigned magnitude, 33-bit compare
        mag = step[DATA_W-1] ? (word_t'(0) - step) : step;
        if ({mag, 1'b0} > {1'b0, ticks_cfg})
        begin
            if (prev < cur)
                step = step + ticks_cfg;
            else
                step = step - ticks_cfg;
        end
        // leap band, lower edge first
        lim = word_t'(leap_cfg);
        acc = leap_sum + step;
        pos = pos_track;
        if ($signed(acc) < $signed(word_t'(0) - lim))
        begin
            acc = acc + lim;
            pos = pos - 1;
        end
        if ($signed(lim) < $signed(acc))
        begin
            acc = acc - lim;
            pos = pos + 1;
        end
        pos = pos + step;
        leap_sum = acc;
        pos_track = pos;
        return pos;
    endfunction

    // watch config, result and sample transactions
    always @(posedge clk or negedge rst_n)
    begin : watch
        word_t want;
        if (!rst_n)
        begin
            ticks_cfg = '0;
            leap_cfg = '0;
            last_sample = '0;
            leap_sum = '0;
            pos_track = '0;
            expected_positions.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TICKS_PER_TURN: ticks_cfg = cfg.data;
                    REG_LEAP_VALUE:     leap_cfg = cfg.data[LEAP_W-1:0];
                    default: ;
                endcase
            end
            // compare before queuing, a result never answers a sample of the same edge
            if (positions.valid && positions.ready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("position: expected none, actual %h", positions.position);
                    fail_count++;
                end
                else
                begin
                    want = expected_positions.pop_front();
                    if (positions.position !== want)
                    begin
                        $error("position: expected %h, actual %h", want, positions.position);
                        fail_count++;
                    end
                end
            end
            if (samples.valid && samples.ready)
                expected_positions.push_back(unwrap_position(samples.raw_count));
        end
        pending_count = expected_positions.size();
    end

endmodule

// ===== tb/sv/tb_encoder_unwrap_leap_tick.sv =====
// testbench top: stimulus, output stalls and verdict for the encoder unwrap block
module tb_encoder_unwrap_leap_tick;
    timeunit 1ns;
    timeprecision 1ps;
    import eul_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic clk;
    logic rst_n;

    eul_in_if  samples_ch();
    eul_out_if positions_ch();
    eul_cfg_if cfg_ch();

    int    fail_count;
    int    pending_count;
    int    cycle_count;
    int    out_stall;
    bit    steady;
    word_t enc_last;

    encoder_unwrap_leap_tick #(
        .RAW_WIDTH (32)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .positions (positions_ch),
        .cfg       (cfg_ch)
    );

    eul_position_checker #(
        .RAW_WIDTH (32)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples       (samples_ch),
        .positions     (positions_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // cycle limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("encoder_unwrap_leap_tick verification failed");
            $finish;
        end
    end

    // result side: random stall after each transaction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            positions_ch.ready <= 1'b0;
            out_stall = 0;
        end
        else if (positions_ch.ready && positions_ch.valid)
        begin
            out_stall = steady ? 0 : $urandom_range(0, 4);
            if (out_stall != 0)
                positions_ch.ready <= 1'b0;
        end
        else if (!positions_ch.ready)
        begin
            if (out_stall != 0)
                out_stall--;
            if (out_stall == 0)
                positions_ch.ready <= 1'b1;
        end
    end

    // one sample transaction with a random gap ahead of it
    task automatic send_sample(input word_t value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.raw_count <= value;
        do @(posedge clk); while (!samples_ch.ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input word_t value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // stop sending and wait until every position has come back
    task automatic settle();
        samples_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (4) @(posedge clk);
    endtask

    // next counter value: mostly smooth motion wrapping at the turn size
    function automatic word_t next_encoder_count(input word_t turn, input int span);
        int     kind;
        longint step;
        longint m;
        word_t  val;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            val = $urandom;
        else if (kind == 1)
        begin
            case ($urandom_range(0, 4))
                0:       val = '0;
                1:       val = '1;
                2:       val = 32'h8000_0000;
                3:       val = 32'h7FFF_FFFF;
                default: val = turn - 1;
            endcase
        end
        else
        begin
            step = longint'($urandom_range(0, 2 * span)) - span;
            if (turn == '0)
                val = enc_last + word_t'(step);
            else
            begin
                m = (longint'(enc_last % turn) + step) % longint'(turn);
                if (m < 0)
                    m = m + longint'(turn);
                val = word_t'(m);
            end
        end
        enc_last = val;
        return val;
    endfunction

    // stimulus
    initial
    begin : stimulus
        word_t bypass_seq[4]  = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hA5A5_A5A5};
        word_t turn_seq[9]    = '{500, 1400, 2300, 10, 4090, 4095, 0, 2048, 0};
        word_t zero_seq[4]    = '{5, 5, 3, 32'hFFFF_FFFF};
        word_t extreme_seq[6] = '{0, 32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                  32'h8000_0000};
        word_t turn;
        word_t leap;
        int    span;
        int    count;

        steady = 1'b0;
        enc_last = '0;
        rst_n = 1'b0;
        samples_ch.valid <= 1'b0;
        samples_ch.raw_count <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_TICKS_PER_TURN;
        cfg_ch.data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bypass out of reset, position follows the sample
        foreach (bypass_seq[i]) send_sample(bypass_seq[i]);
        settle();

        // normal mode: wrap both ways, leap at the lower bound, half-turn boundary
        write_reg(REG_TICKS_PER_TURN, 32'd4096);
        write_reg(REG_LEAP_VALUE, 32'd1000);
        foreach (turn_seq[i]) send_sample(turn_seq[i]);
        settle();

        // zero turn size, smallest leap
        write_reg(REG_TICKS_PER_TURN, '0);
        write_reg(REG_LEAP_VALUE, 32'd1);
        foreach (zero_seq[i]) send_sample(zero_seq[i]);
        settle();

        // largest turn and leap, most negative step
        write_reg(REG_TICKS_PER_TURN, 32'hFFFF_FFFF);
        write_reg(REG_LEAP_VALUE, 32'h7FFF_FFFF);
        foreach (extreme_seq[i]) send_sample(extreme_seq[i]);
        enc_last = 32'h8000_0000;

        // random phases, each with its own settings
        for (int ph = 0; ph < 12; ph++)
        begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0:       turn = '0;
                1:       turn = '1;
                2:       turn = $urandom;
                3:       turn = 32'd4096;
                default: turn = $urandom_range(2, 100000);
            endcase
            case ($urandom_range(0, 5))
                0:       leap = '0;
                1:       leap = 32'd1;
                2:       leap = 32'h7FFF_FFFF;
                3:       leap = $urandom & 32'h7FFF_FFFF;
                default: leap = $urandom_range(1, 20000);
            endcase
            write_reg(REG_TICKS_PER_TURN, turn);
            write_reg(REG_LEAP_VALUE, leap);
            span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 50) : $urandom_range(1, 30000);
            count = $urandom_range(90, 120);
            repeat (count) send_sample(next_encoder_count(turn, span));
        end

        // drain and verdict
        steady = 1'b0;
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("encoder_unwrap_leap_tick verification clean");
        else
            $display("encoder_unwrap_leap_tick verification failed");
        $finish;
    end

endmodule
